FILE: rtl/core/fsr_pkg.sv
// shared constants, types and helpers for the error-diffusion requantizer
package fsr_pkg;

  // line geometry
  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH + 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = COL_W + 1;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  // field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int SCALE_W    = 26;
  localparam int OFFSET_W   = 25;
  localparam int BITS_W     = 5;
  localparam int ROW_W      = 13;
  localparam int CFG_DATA_W = 26;
  localparam int CFG_IDX_W  = 2;

  // fixed point layout
  localparam int FRAC_BITS  = 8;
  localparam int ERR_W      = FRAC_BITS + 2;
  localparam int PREC       = FRAC_BITS + 20;
  localparam int DROP       = PREC - FRAC_BITS;
  localparam int ERR_SHIFT  = 16;
  localparam int PROD_W     = SAMPLE_W + SCALE_W;
  localparam int RAW_W      = PROD_W + FRAC_BITS + 6;
  localparam int BASE_W     = LEVEL_W + PREC + 2;
  localparam int SUM_W      = BASE_W + 1;
  localparam int XQ_W       = LEVEL_W + FRAC_BITS;
  localparam int WSUM_W     = ERR_W + 4;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // line store entry that holds column zero
  localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(1);

  // register reset values
  localparam logic [SCALE_W-1:0]  SCALE_RST     = SCALE_W'(65536);
  localparam logic [BITS_W-1:0]   OUT_BITS_RST  = BITS_W'(8);
  localparam logic [ROW_W-1:0]    ROW_WIDTH_RST = ROW_W'(4096);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE,
    REG_OFFSET,
    REG_OUT_BITS,
    REG_ROW_WIDTH
  } cfg_reg_t;

  // where a neighbor error comes from
  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_D1,
    SRC_D2
  } src_t;

  // one classified pixel
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                col0;
    logic                tr_zero;
    logic                top_zero;
    src_t                tr_src;
    src_t                top_src;
    logic [ADDR_W-1:0]   tr_addr;
    logic [ADDR_W-1:0]   wr_addr;
  } pix_item_t;

  // largest output level for a given depth setting
  function automatic logic [LEVEL_W-1:0] max_level(input logic [BITS_W-1:0] ob);
    logic [BITS_W-1:0] b;
    b = ob;
    if (ob == '0) begin
      b = BITS_W'(1);
    end else if (ob > BITS_W'(LEVEL_W)) begin
      b = BITS_W'(LEVEL_W);
    end
    return ~({LEVEL_W{1'b1}} << b);
  endfunction

endpackage

FILE: rtl/core/fsr_front.sv
// front end: tracks column and row, picks line store addresses and bypass sources
module fsr_front
  import fsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  input  logic                in_tuser,   // [0] frame_start
  input  logic [ROW_W-1:0]    row_width,
  input  logic                q_full,
  output logic                push,
  output pix_item_t           push_item
);

  logic [COL_W-1:0]   column_r, column_nxt;
  logic               first_row_r, first_row_nxt;
  logic [ADDR_W-1:0]  wa1_r, wa2_r;
  logic               v1_r, v2_r;

  logic [COL_W-1:0]   col;
  logic               fr;
  logic [WIDTH_W-1:0] width;
  logic [WIDTH_W-1:0] col_p1;
  logic               last;
  logic [ADDR_W-1:0]  wr_addr, tr_addr;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  // effective row width
  always_comb begin
    if (row_width == '0) begin
      width = WIDTH_W'(1);
    end else if (int'(row_width) > MAX_WIDTH) begin
      width = WIDTH_W'(MAX_WIDTH);
    end else begin
      width = WIDTH_W'(row_width);
    end
  end

  // position of this pixel
  always_comb begin
    col     = in_tuser ? '0 : column_r;
    fr      = in_tuser || first_row_r;
    col_p1  = WIDTH_W'(col) + WIDTH_W'(1);
    last    = col_p1 >= width;
    wr_addr = ADDR_W'(col) + ADDR_W'(1);
    tr_addr = ADDR_W'(col) + ADDR_W'(2);
  end

  // classify the item, bypass from the two most recent writes
  always_comb begin
    push_item.sample   = in_tdata;
    push_item.last     = last;
    push_item.col0     = (col == '0);
    push_item.tr_zero  = last || fr;
    push_item.top_zero = fr;
    push_item.tr_addr  = tr_addr;
    push_item.wr_addr  = wr_addr;
    if (v1_r && tr_addr == wa1_r) begin
      push_item.tr_src = SRC_D1;
    end else if (v2_r && tr_addr == wa2_r) begin
      push_item.tr_src = SRC_D2;
    end else begin
      push_item.tr_src = SRC_MEM;
    end
    if (v1_r && TOP_ADDR == wa1_r) begin
      push_item.top_src = SRC_D1;
    end else if (v2_r && TOP_ADDR == wa2_r) begin
      push_item.top_src = SRC_D2;
    end else begin
      push_item.top_src = SRC_MEM;
    end
  end

  // next position
  always_comb begin
    column_nxt    = last ? '0 : COL_W'(col_p1);
    first_row_nxt = last ? 1'b0 : fr;
  end

  // state update on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      first_row_r <= 1'b1;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      wa1_r       <= '0;
      wa2_r       <= '0;
    end else if (push) begin
      column_r    <= column_nxt;
      first_row_r <= first_row_nxt;
      v1_r        <= 1'b1;
      v2_r        <= v1_r;
      wa1_r       <= wr_addr;
      wa2_r       <= wa1_r;
    end
  end

endmodule

FILE: rtl/core/fsr_queue.sv
// short queue of classified pixels between front and back
module fsr_queue
  import fsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pix_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output pix_item_t head_item
);

  pix_item_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = entry_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/core/fsr_back.sv
// back end: gain, error diffusion, clamp and rounding, line store, output register
module fsr_back
  import fsr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  pix_item_t                  q_head,
  output logic                       q_pop,
  input  logic [SCALE_W-1:0]         scale,
  input  logic signed [OFFSET_W-1:0] offset,
  input  logic [BITS_W-1:0]          out_bits,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [LEVEL_W-1:0]         out_tdata,
  output logic                       out_tlast
);

  // line store of errors, entry c+1 holds column c
  logic [ERR_W-1:0] line_mem [LINE_DEPTH];

  // stage a: product and line store reads
  logic                    a_v_r;
  pix_item_t               a_item_r;
  logic [PROD_W-1:0]       prod_r;
  logic [ERR_W-1:0]        rd_tr_r, rd_top_r;

  // stage l: base sum and stored errors
  logic                    l_v_r;
  pix_item_t               l_item_r;
  logic signed [BASE_W-1:0] base_r;
  logic [ERR_W-1:0]        tr_l_r, top_l_r;

  // diffusion state
  logic [ERR_W-1:0]        err_r, err2_r, above_r, above_left_r;

  // output register
  logic                    out_v_r;
  logic [LEVEL_W-1:0]      level_r;
  logic                    last_r;

  // handshake between stages
  logic adv_out, l_free, adv_l, a_free;

  logic signed [RAW_W-1:0]  raw_c;
  logic signed [BASE_W-1:0] base_c;
  logic [RAW_W-BASE_W:0]    raw_hi;

  logic signed [ERR_W-1:0]  e_left, e_tr, e_top, e_tl;
  logic signed [WSUM_W-1:0] wsum;
  logic signed [SUM_W-1:0]  sum_c;
  logic [SUM_W-2:0]         limit, clamp_c;
  logic [XQ_W-1:0]          xq;
  logic [LEVEL_W-1:0]       q_lo;
  logic [FRAC_BITS-1:0]     frac;
  logic                     up;
  logic [LEVEL_W-1:0]       level_c;
  logic [ERR_W-1:0]         err_c;

  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  function automatic logic [ERR_W-1:0] pick(input src_t src, input logic [ERR_W-1:0] mem_val,
                                            input logic [ERR_W-1:0] d1,
                                            input logic [ERR_W-1:0] d2);
    logic [ERR_W-1:0] v;
    case (src)
      SRC_D1:  v = d1;
      SRC_D2:  v = d2;
      default: v = mem_val;
    endcase
    return v;
  endfunction

  function automatic logic signed [WSUM_W-1:0] ext(input logic signed [ERR_W-1:0] e);
    return {{(WSUM_W-ERR_W){e[ERR_W-1]}}, e};
  endfunction

  assign adv_out    = l_v_r && (!out_v_r || out_tready);
  assign l_free     = !l_v_r || adv_out;
  assign adv_l      = a_v_r && l_free;
  assign a_free     = !a_v_r || adv_l;
  assign q_pop      = !q_empty && a_free;

  assign out_tvalid = out_v_r;
  assign out_tdata  = level_r;
  assign out_tlast  = last_r;

  // gain plus offset, saturated to a range that still clamps the same
  always_comb begin
    raw_c = $signed({{(RAW_W-PROD_W-FRAC_BITS-4){1'b0}}, prod_r, {(FRAC_BITS+4){1'b0}}})
          + $signed({{(RAW_W-OFFSET_W-FRAC_BITS-12){offset[OFFSET_W-1]}}, offset,
                     {(FRAC_BITS+12){1'b0}}});
    raw_hi = raw_c[RAW_W-1:BASE_W-1];
    if (raw_hi == '0 || raw_hi == '1) begin
      base_c = raw_c[BASE_W-1:0];
    end else if (raw_c[RAW_W-1]) begin
      base_c = {1'b1, {(BASE_W-1){1'b0}}};
    end else begin
      base_c = {1'b0, {(BASE_W-1){1'b1}}};
    end
  end

  // neighbor errors with bypass of the two latest results
  always_comb begin
    e_left = l_item_r.col0 ? '0 : err_r;
    e_tl   = l_item_r.col0 ? '0 : above_left_r;
    e_tr   = l_item_r.tr_zero ? '0 : pick(l_item_r.tr_src, tr_l_r, err_r, err2_r);
    if (!l_item_r.col0) begin
      e_top = above_r;
    end else if (l_item_r.top_zero) begin
      e_top = '0;
    end else begin
      e_top = pick(l_item_r.top_src, top_l_r, err_r, err2_r);
    end
    wsum = (ext(e_left) <<< 3) - ext(e_left)
         + (ext(e_tr) <<< 1) + ext(e_tr)
         + (ext(e_top) <<< 2) + ext(e_top)
         + ext(e_tl);
  end

  // add error, clamp, round half to even
  always_comb begin
    sum_c = $signed({base_r[BASE_W-1], base_r})
          + $signed({{(SUM_W-WSUM_W-ERR_SHIFT){wsum[WSUM_W-1]}}, wsum, {ERR_SHIFT{1'b0}}});
    limit = {{(SUM_W-1-LEVEL_W-PREC){1'b0}}, max_level(out_bits), {PREC{1'b0}}};
    if (sum_c[SUM_W-1]) begin
      clamp_c = '0;
    end else if (sum_c[SUM_W-2:0] > limit) begin
      clamp_c = limit;
    end else begin
      clamp_c = sum_c[SUM_W-2:0];
    end
    xq      = clamp_c[DROP +: XQ_W];
    q_lo    = xq[XQ_W-1:FRAC_BITS];
    frac    = xq[FRAC_BITS-1:0];
    up      = (frac > HALF) || (frac == HALF && q_lo[0]);
    level_c = q_lo + LEVEL_W'(up);
    err_c   = up ? {2'b11, frac} : {2'b00, frac};
  end

  // stage valid flags and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      l_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_r <= q_pop;
      end
      if (l_free) begin
        l_v_r <= adv_l;
      end
      if (adv_out) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // diffusion state, updated as each result leaves the loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r        <= '0;
      err2_r       <= '0;
      above_r      <= '0;
      above_left_r <= '0;
    end else if (adv_out) begin
      err_r        <= err_c;
      err2_r       <= err_r;
      above_r      <= e_tr;
      above_left_r <= e_top;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_item_r <= q_head;
      prod_r   <= PROD_W'(q_head.sample) * PROD_W'(scale);
    end
    if (adv_l) begin
      l_item_r <= a_item_r;
      base_r   <= base_c;
      tr_l_r   <= rd_tr_r;
      top_l_r  <= rd_top_r;
    end
    if (adv_out) begin
      level_r <= level_c;
      last_r  <= l_item_r.last;
    end
  end

  // line store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (adv_out) begin
      line_mem[l_item_r.wr_addr] <= err_c;
    end
    if (q_pop) begin
      rd_tr_r  <= line_mem[q_head.tr_addr];
      rd_top_r <= line_mem[TOP_ADDR];
    end
  end

endmodule

FILE: rtl/core/floyd_steinberg_requantizer.sv
// top level: configuration registers and front, queue and back instances
//
// Requantizes a raster stream of unsigned pixels with error diffusion.
// Input transfers carry one pixel in in_tdata and a frame start flag in
// in_tuser; each produces exactly one output transfer with the quantized
// level in out_tdata and out_tlast set on the last pixel of a row.
// Registers are written through cfg_we/cfg_index/cfg_wdata: gain, offset,
// output depth and row width. The user must write them only while the
// stream is idle; the block does not enforce it. Pixels pass the queue,
// stage a, stage l and the output register. Unless the receiver stalls,
// the block takes one pixel per clock; the add, clamp and round loop
// that feeds each error to the next pixel sets that rate, and the line
// store has one write and two read ports per cycle. A four-entry queue
// sits between the classifying front end and the arithmetic back end, so
// in_tready depends only on queue space. When the receiver stalls, the
// output register holds, the back end stops, the queue fills and
// in_tready drops. Reset loads the register defaults, returns to column
// zero of a first row and needs no clearing pass: the line store is only
// read for rows that follow a row which wrote it.
module floyd_steinberg_requantizer
  import fsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  input  logic                  in_tuser,   // [0] frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [LEVEL_W-1:0]    out_tdata,  // [15:0] level
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [SCALE_W-1:0]         scale_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic [BITS_W-1:0]          out_bits_r;
  logic [ROW_W-1:0]           row_width_r;

  logic      push, q_full, q_pop, q_empty;
  pix_item_t push_item, q_head;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_RST;
      offset_r    <= '0;
      out_bits_r  <= OUT_BITS_RST;
      row_width_r <= ROW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCALE:     scale_r     <= cfg_wdata[SCALE_W-1:0];
        REG_OFFSET:    offset_r    <= $signed(cfg_wdata[OFFSET_W-1:0]);
        REG_OUT_BITS:  out_bits_r  <= cfg_wdata[BITS_W-1:0];
        REG_ROW_WIDTH: row_width_r <= cfg_wdata[ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // classify pixels
  fsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .row_width (row_width_r),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  fsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_head)
  );

  // arithmetic and line store
  fsr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .scale      (scale_r),
    .offset     (offset_r),
    .out_bits   (out_bits_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: bench/testbench.sv
// self-checking stream testbench for the floyd_steinberg_requantizer block
module testbench;
  import fsr_pkg::*;

  // expected output pixel
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               row_end;
  } pixel_out_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;   // [15:0] sample
  logic                  in_tuser;   // [0] frame_start
  logic                  out_tvalid;
  logic                  out_tready;
  logic [LEVEL_W-1:0]    out_tdata;  // [15:0] level
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  floyd_steinberg_requantizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // register mirrors
  logic [SCALE_W-1:0]         gain_r;
  logic signed [OFFSET_W-1:0] ofs_r;
  logic [BITS_W-1:0]          depth_r;
  logic [ROW_W-1:0]           width_r;

  // diffusion state mirror
  logic signed [ERR_W-1:0] err_store [LINE_DEPTH];
  logic signed [ERR_W-1:0] prev_err;
  logic signed [ERR_W-1:0] err_above;
  logic signed [ERR_W-1:0] err_above_left;
  logic [COL_W-1:0]        col_pos;
  logic                    in_first_row;
  int                      store_filled;

  pixel_out_t expected_q[$];

  // traffic shaping
  logic idle_in;
  logic idle_out;
  int   out_stall;
  int   hold_off_cycles;

  // bookkeeping
  int pixels_sent;
  int settings_applied;
  int rows_seen;
  int mismatches;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int active_width();
    if (width_r == '0) return 1;
    if (int'(width_r) > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_r);
  endfunction

  function automatic int active_depth();
    if (depth_r == '0) return 1;
    if (int'(depth_r) > LEVEL_W) return LEVEL_W;
    return int'(depth_r);
  endfunction

  // scale, add diffused error, clamp, round half to even; updates the mirror
  function automatic pixel_out_t diffuse_pixel(input logic [SAMPLE_W-1:0] smp,
                                               input logic fs);
    int         c;
    int         e_left;
    int         e_tr;
    int         e_top;
    int         e_tl;
    logic       last;
    longint     acc;
    longint     ceiling;
    longint     xq;
    longint     q;
    longint     frac;
    longint     half;
    longint     err;
    pixel_out_t r;
    if (fs) begin
      col_pos = '0;
      in_first_row = 1'b1;
    end
    c = int'(col_pos);
    last = (c + 1 >= active_width());
    // neighbors: row edges and the first row read zero
    if (c == 0) begin
      e_left = 0;
      e_tl = 0;
      e_top = in_first_row ? 0 : err_store[1];
    end else begin
      e_left = prev_err;
      e_tl = err_above_left;
      e_top = err_above;
    end
    e_tr = (last || in_first_row) ? 0 : err_store[c + 2];
    // exact sum at FRAC_BITS+20 fractional bits
    acc = (longint'(smp) * longint'(gain_r)) <<< (FRAC_BITS + 4);
    acc = acc + (longint'(ofs_r) <<< (FRAC_BITS + 12));
    acc = acc + (longint'(7 * e_left + 3 * e_tr + 5 * e_top + e_tl) <<< 16);
    ceiling = ((longint'(1) <<< active_depth()) - 1) <<< (FRAC_BITS + 20);
    if (acc < 0) acc = 0;
    if (acc > ceiling) acc = ceiling;
    // truncate to FRAC_BITS, then round half to even
    xq = acc >>> 20;
    q = xq >>> FRAC_BITS;
    frac = xq - (q <<< FRAC_BITS);
    half = longint'(1) <<< (FRAC_BITS - 1);
    if (frac > half || (frac == half && q[0] == 1'b1)) q = q + 1;
    err = xq - (q <<< FRAC_BITS);
    err_store[c + 1] = ERR_W'(err);
    prev_err = ERR_W'(err);
    err_above_left = ERR_W'(e_top);
    err_above = ERR_W'(e_tr);
    if (c + 1 > store_filled) store_filled = c + 1;
    r.level = q[LEVEL_W-1:0];
    r.row_end = last;
    if (last) begin
      col_pos = '0;
      in_first_row = 1'b0;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return r;
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic send_pixel(input logic [SAMPLE_W-1:0] smp, input logic fs);
    int   gap;
    logic start;
    start = fs;
    // a row wider than anything stored so far must open a new frame
    if (!in_first_row && active_width() > store_filled) start = 1'b1;
    gap = idle_in ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    expected_q.push_back(diffuse_pixel(smp, start));
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait for every expected pixel plus pipeline slack
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  // write all four registers back to back while idle
  task automatic apply_settings(input logic [SCALE_W-1:0] gain,
                                input logic signed [OFFSET_W-1:0] ofs,
                                input logic [BITS_W-1:0] depth,
                                input logic [ROW_W-1:0] wid);
    gain_r = gain;
    ofs_r = ofs;
    depth_r = depth;
    width_r = wid;
    settings_applied++;
    cfg_we <= 1'b1;
    cfg_index <= REG_SCALE;
    cfg_wdata <= CFG_DATA_W'(gain);
    @(negedge clk);
    cfg_index <= REG_OFFSET;
    cfg_wdata <= {1'b0, ofs};
    @(negedge clk);
    cfg_index <= REG_OUT_BITS;
    cfg_wdata <= CFG_DATA_W'(depth);
    @(negedge clk);
    cfg_index <= REG_ROW_WIDTH;
    cfg_wdata <= CFG_DATA_W'(wid);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // exact half ties on the first pixel of a frame, even and odd level
  task automatic test_tie_rounding();
    apply_settings(26'd65536, 25'sd128, 5'd8, 13'd3);
    send_pixel(16'd2, 1'b1);
    send_pixel(16'd3, 1'b0);
    send_pixel(16'd4, 1'b0);
    send_pixel(16'd5, 1'b1);
    send_pixel(16'd6, 1'b0);
    send_pixel(16'd7, 1'b0);
    drain();
  endtask

  // clamp at both ends, depth and width outside their range
  task automatic test_clamp_and_depth();
    apply_settings(26'h3FFFFFF, 25'sd16777215, 5'd16, 13'd2);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    drain();
    apply_settings(26'd0, -25'sd16777216, 5'd31, 13'd2);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h5555, 1'b0);
    drain();
    apply_settings(26'd65536, 25'sd0, 5'd0, 13'd0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'd1, 1'b0);
    drain();
  endtask

  // frame start arriving in the middle of a row
  task automatic test_frame_restart();
    apply_settings(26'd40000, 25'sd77, 5'd4, 13'd4);
    send_pixel(16'd9000, 1'b1);
    send_pixel(16'd12345, 1'b0);
    send_pixel(16'd30000, 1'b0);
    send_pixel(16'd777, 1'b0);
    send_pixel(16'd2222, 1'b0);
    send_pixel(16'd4444, 1'b1);
    send_pixel(16'd6666, 1'b0);
    drain();
  endtask

  // row width reduced while the column sits past the new last column
  task automatic test_width_shrink();
    apply_settings(26'd65536, 25'sd64, 5'd8, 13'd4);
    send_pixel(16'd10, 1'b1);
    send_pixel(16'd200, 1'b0);
    send_pixel(16'd33, 1'b0);
    send_pixel(16'd129, 1'b0);
    send_pixel(16'd60, 1'b0);
    send_pixel(16'd61, 1'b0);
    drain();
    apply_settings(26'd65536, 25'sd64, 5'd8, 13'd2);
    send_pixel(16'd99, 1'b0);
    send_pixel(16'd100, 1'b0);
    drain();
  endtask

  // receiver holds off long enough for the queue to fill and stall the input
  task automatic test_backpressure();
    apply_settings(26'd256, 25'sd0, 5'd8, 13'd7);
    idle_in = 1'b0;
    idle_out = 1'b0;
    @(posedge clk);
    hold_off_cycles = 100;
    @(negedge clk);
    for (int i = 0; i < 48; i++) begin
      send_pixel(16'($urandom), (i == 0));
    end
    drain();
  endtask

  // width register above the maximum, long partial row at the widest setting
  task automatic test_widest_row();
    apply_settings(26'd65536, 25'sd0, 5'd8, 13'd8191);
    idle_in = 1'b1;
    idle_out = 1'b1;
    for (int i = 0; i < 160; i++) begin
      send_pixel(16'($urandom_range(0, 255)), (i == 0));
    end
    drain();
  endtask

  // random settings per phase, random pixels and frame starts
  task automatic test_random_settings();
    logic [SCALE_W-1:0]         gain;
    logic signed [OFFSET_W-1:0] ofs;
    logic [BITS_W-1:0]          depth;
    logic [ROW_W-1:0]           wid;
    logic [SAMPLE_W-1:0]        smp;
    int                         nb;
    int                         count;
    for (int p = 0; p < 10; p++) begin
      depth = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
      nb = (depth == '0) ? 1 : ((int'(depth) > LEVEL_W) ? LEVEL_W : int'(depth));
      case ($urandom_range(0, 5))
        0: gain = 26'd65536;
        1: gain = 26'd0;
        2: gain = 26'h3FFFFFF;
        3: gain = 26'($urandom);
        default: gain = 26'((1 << nb) + $urandom_range(0, 1 << nb));
      endcase
      case ($urandom_range(0, 5))
        0: ofs = '0;
        1: ofs = -25'sd16777216;
        2: ofs = 25'sd16777215;
        3: ofs = 25'($urandom);
        default: ofs = 25'($urandom_range(0, 1024) - 512);
      endcase
      case ($urandom_range(0, 7))
        0: wid = 13'd0;
        1: wid = 13'd1;
        6: wid = 13'($urandom_range(13, 300));
        7: wid = ($urandom_range(0, 1) == 1) ? 13'd8191 : 13'd4096;
        default: wid = 13'($urandom_range(2, 12));
      endcase
      apply_settings(gain, ofs, depth, wid);
      idle_in = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      count = $urandom_range(100, 160);
      for (int i = 0; i < count; i++) begin
        case ($urandom_range(0, 5))
          2: smp = 16'($urandom_range(0, 255));
          3: smp = 16'h0000;
          4: smp = 16'hFFFF;
          5: smp = 16'(1 << $urandom_range(0, 15));
          default: smp = 16'($urandom);
        endcase
        send_pixel(smp, ($urandom_range(0, 63) == 0) || (i == 0 && $urandom_range(0, 2) == 0));
      end
      drain();
    end
  endtask

  // receiver ready: long hold-off first, then per-pixel stalls
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_tready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each output transfer with the oldest expected pixel
  always @(posedge clk) begin : check_out
    pixel_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected transfer at %0t: level %0d row_end %0b",
                   $time, out_tdata, out_tlast);
        end
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata !== want.level || out_tlast !== want.row_end) begin
          if (mismatches < 10) begin
            $display("mismatch at %0t: level exp %0d got %0d, row_end exp %0b got %0b",
                     $time, want.level, out_tdata, want.row_end, out_tlast);
          end
          mismatches++;
        end
        if (want.row_end) rows_seen++;
      end
      out_stall = idle_out ? $urandom_range(0, 5) : 0;
    end
  end

  initial begin : main
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SCALE;
    cfg_wdata = '0;
    idle_in = 1'b0;
    idle_out = 1'b0;
    out_stall = 0;
    hold_off_cycles = 0;
    pixels_sent = 0;
    settings_applied = 0;
    rows_seen = 0;
    mismatches = 0;
    // mirror of the reset state
    gain_r = SCALE_RST;
    ofs_r = '0;
    depth_r = OUT_BITS_RST;
    width_r = ROW_WIDTH_RST;
    prev_err = '0;
    err_above = '0;
    err_above_left = '0;
    col_pos = '0;
    in_first_row = 1'b1;
    store_filled = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_tie_rounding();
    test_clamp_and_depth();
    test_frame_restart();
    test_width_shrink();
    test_backpressure();
    test_widest_row();
    test_random_settings();

    $display("run covered %0d pixels and %0d finished rows over %0d register settings,",
             pixels_sent, rows_seen, settings_applied);
    $display("with a stalled receiver, frame restarts and out-of-range settings; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: floyd_steinberg_requantizer.f
rtl/core/fsr_pkg.sv
rtl/core/fsr_front.sv
rtl/core/fsr_queue.sv
rtl/core/fsr_back.sv
rtl/core/floyd_steinberg_requantizer.sv
bench/testbench.sv
